[sv/assert_macros.svh]
// Assertion helpers shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B64D_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b64d assertion failed");

// Next-cycle implication, disabled during reset.
`define B64D_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b64d assertion failed");

`endif

[sv/b64d_pkg.sv]
package b64d_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;
   localparam logic [1:0] POS_FOURTH = 2'd3;

   localparam logic [1:0] IDX_FIRST  = 2'd0;
   localparam logic [1:0] IDX_SECOND = 2'd1;
   localparam logic [1:0] IDX_THIRD  = 2'd2;

   // One queued job: the result items of one group or one error, in emission order.
   typedef struct packed {
      logic [7:0] data0;
      logic [7:0] data1;
      logic [7:0] data2;
      logic [1:0] last_idx;
      logic       str_last;
      logic       err;
   } job_type;

   // Bit 6 set means the character is outside the alphabet.
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] v;
      v = 7'h40;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = {1'b0, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = {1'b0, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
         v = 7'd62;
      end else if (c == 8'h2F) begin
         v = 7'd63;
      end
      return v;
   endfunction

endpackage

[sv/b64d_front.sv]
module b64d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_in_char,
   input  logic              req_in_last,
   input  logic              q_full,
   output logic              push,
   output b64d_pkg::job_type push_job
);
   import b64d_pkg::*;

   logic [1:0]  pos_ff, pos_in;
   logic [17:0] held_ff, held_in;
   logic        tpad_ff, tpad_in;
   logic        ginv_ff, ginv_in;
   logic        disc_ff, disc_in;

   logic        accept;
   logic [6:0]  sx;
   logic        pad;
   logic        alpha_bad;
   logic        bad;
   logic        inv;
   logic [5:0]  v;
   logic [23:0] n;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign sx        = sextet_of(req_in_char);
   assign pad       = (req_in_char == PAD_CHAR);
   assign alpha_bad = sx[6];
   assign v         = (pad || alpha_bad) ? 6'd0 : sx[5:0];
   assign n         = {held_ff, v};

   always_comb begin
      unique case (pos_ff)
         POS_FIRST, POS_SECOND: bad = alpha_bad;
         POS_THIRD:             bad = !pad && alpha_bad;
         default:               bad = (!pad && alpha_bad) || (tpad_ff && !pad);
      endcase
      inv = ginv_ff || bad;
   end

   always_comb begin
      pos_in   = pos_ff;
      held_in  = held_ff;
      tpad_in  = tpad_ff;
      ginv_in  = ginv_ff;
      disc_in  = disc_ff;
      push     = 1'b0;
      push_job = '{data0: 8'd0, data1: 8'd0, data2: 8'd0, last_idx: IDX_FIRST,
                   str_last: 1'b1, err: 1'b1};
      if (accept) begin
         if (disc_ff) begin
            if (req_in_last) begin
               disc_in = 1'b0;
            end
         end else if (pos_ff != POS_FOURTH) begin
            if (req_in_last) begin
               push    = 1'b1;
               pos_in  = POS_FIRST;
               held_in = '0;
               tpad_in = 1'b0;
               ginv_in = 1'b0;
            end else begin
               if (pos_ff == POS_THIRD) begin
                  tpad_in = pad;
               end
               ginv_in = inv;
               held_in = {held_ff[11:0], v};
               pos_in  = pos_ff + 2'd1;
            end
         end else begin
            push    = 1'b1;
            pos_in  = POS_FIRST;
            held_in = '0;
            tpad_in = 1'b0;
            ginv_in = 1'b0;
            if (inv) begin
               disc_in = !req_in_last;
            end else begin
               push_job.err      = 1'b0;
               push_job.str_last = req_in_last;
               push_job.data0    = n[23:16];
               push_job.data1    = tpad_ff ? n[7:0] : n[15:8];
               push_job.data2    = n[7:0];
               priority if (tpad_ff && pad) begin
                  push_job.last_idx = IDX_FIRST;
               end else if (tpad_ff || pad) begin
                  push_job.last_idx = IDX_SECOND;
               end else begin
                  push_job.last_idx = IDX_THIRD;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_FIRST;
         held_ff <= '0;
         tpad_ff <= 1'b0;
         ginv_ff <= 1'b0;
         disc_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         held_ff <= held_in;
         tpad_ff <= tpad_in;
         ginv_ff <= ginv_in;
         disc_ff <= disc_in;
      end
   end

endmodule

[sv/b64d_queue.sv]
`include "assert_macros.svh"

module b64d_queue #(
   parameter int Depth = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64d_pkg::job_type push_job,
   input  logic              pop,
   output logic              q_full,
   output logic              q_valid,
   output b64d_pkg::job_type q_head
);
   import b64d_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   job_type             mem_ff [Depth];
   logic [PtrW-1:0]     wr_ff, wr_in;
   logic [PtrW-1:0]     rd_ff, rd_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;

   assign q_full  = (cnt_ff == CntW'(Depth));
   assign q_valid = (cnt_ff != '0);
   assign q_head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   `B64D_ASSERT_IMP(a_no_push_full, clock, reset, push, !q_full)
   `B64D_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, q_valid)
   `B64D_ASSERT_NXT(a_drain_empty, clock, reset, pop && !push && cnt_ff == CntW'(1), !q_valid)

endmodule

[sv/b64d_back.sv]
`include "assert_macros.svh"

module b64d_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  b64d_pkg::job_type q_head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_end,
   output logic              rsp_string_end,
   output logic              rsp_decode_error
);
   import b64d_pkg::*;

   job_type    cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       run_end_ff, run_end_in;
   logic       str_end_ff, str_end_in;
   logic       err_ff, err_in;

   logic       out_free;
   logic       emit;
   logic       emit_last;
   logic [7:0] sel_byte;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = cur_valid_ff && out_free;
   assign emit_last = emit && (idx_ff == cur_ff.last_idx);
   assign pop       = q_valid && (!cur_valid_ff || emit_last);

   always_comb begin
      unique case (idx_ff)
         IDX_FIRST:  sel_byte = cur_ff.data0;
         IDX_SECOND: sel_byte = cur_ff.data1;
         default:    sel_byte = cur_ff.data2;
      endcase
   end

   always_comb begin
      cur_in       = pop ? q_head : cur_ff;
      cur_valid_in = pop || (cur_valid_ff && !emit_last);
      idx_in       = pop ? IDX_FIRST : (emit ? idx_ff + 2'd1 : idx_ff);
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      byte_in      = emit ? sel_byte : byte_ff;
      run_end_in   = emit ? (idx_ff == cur_ff.last_idx) : run_end_ff;
      str_end_in   = emit ? ((idx_ff == cur_ff.last_idx) && cur_ff.str_last) : str_end_ff;
      err_in       = emit ? cur_ff.err : err_ff;
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      byte_ff    <= byte_in;
      run_end_ff <= run_end_in;
      str_end_ff <= str_end_in;
      err_ff     <= err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= IDX_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_run_end      = run_end_ff;
   assign rsp_string_end   = str_end_ff;
   assign rsp_decode_error = err_ff;

   `B64D_ASSERT_IMP(a_idx_bound, clock, reset, cur_valid_ff, idx_ff <= cur_ff.last_idx)
   `B64D_ASSERT_IMP(a_err_form, clock, reset, rsp_valid_ff && err_ff,
      run_end_ff && str_end_ff && byte_ff == 8'd0)

endmodule

[sv/base64_stream_decoder_unit.sv]
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_in_char, req_in_last
// rsp      out        rsp_valid/rsp_stall   rsp_out_byte, rsp_run_end,
//                                           rsp_string_end, rsp_decode_error
//
// One character is taken every cycle while the job queue has room.
// Result items leave one per cycle from the output register while rsp is not
// stalled; the back end sets this pace from the queue via its job register.
// Reset is synchronous and clears the group state, the queue and the output.
// A stall on rsp fills the queue, and req_stall rises when it is full.
module base64_stream_decoder_unit #(
   parameter int QueueDepth = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end,
   output logic       rsp_string_end,
   output logic       rsp_decode_error
);
   import b64d_pkg::*;

   logic    push;
   job_type push_job;
   logic    pop;
   logic    q_full;
   logic    q_valid;
   job_type q_head;

   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_char (req_in_char),
      .req_in_last (req_in_last),
      .q_full      (q_full),
      .push        (push),
      .push_job    (push_job)
   );

   b64d_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .q_full   (q_full),
      .q_valid  (q_valid),
      .q_head   (q_head)
   );

   b64d_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_end      (rsp_run_end),
      .rsp_string_end   (rsp_string_end),
      .rsp_decode_error (rsp_decode_error)
   );

endmodule
